// ===== design/tse_pkg.sv =====
// Shared widths, control bundle and reciprocal table for the Taylor sine evaluator.
package tse_pkg;

    localparam int ANGLE_W  = 32;
    localparam int CFG_W    = 4;
    localparam int X2_W     = 35;
    localparam int RECIP_W  = 30;
    localparam int F_W      = 32;
    localparam int LO_W     = 36;
    localparam int TERM_W   = 47;
    localparam int FULL_W   = 52;
    localparam int ACC_W    = 53;
    localparam int SINE_W   = 48;
    localparam int MA_W     = 35;
    localparam int MB_W     = 32;
    localparam int PROD_W   = MA_W + MB_W;

    localparam logic [CFG_W-1:0]  TERM_COUNT_RESET = 4'd5;
    localparam logic [TERM_W-1:0] TERM_LIMIT       = {TERM_W{1'b1}};
    localparam logic [SINE_W-1:0] SUM_HIGH         = {1'b0, {(SINE_W-1){1'b1}}};
    localparam logic [SINE_W-1:0] SUM_LOW          = {1'b1, {(SINE_W-1){1'b0}}};

    typedef struct packed {
        logic             accept;
        logic             sq;
        logic             x2;
        logic             lo;
        logic             hi;
        logic             acc;
        logic             finish;
        logic [CFG_W-1:0] k;
    } t_ctrl;

    // Rounded Q0.32 reciprocal of (2k)(2k+1)
    function automatic logic [RECIP_W-1:0] recip(input logic [CFG_W-1:0] k);
        logic [RECIP_W-1:0] r;
        unique case (k)
            4'd1:    r = 30'd715827883;
            4'd2:    r = 30'd214748365;
            4'd3:    r = 30'd102261126;
            4'd4:    r = 30'd59652324;
            4'd5:    r = 30'd39045157;
            4'd6:    r = 30'd27531842;
            4'd7:    r = 30'd20452225;
            4'd8:    r = 30'd15790321;
            4'd9:    r = 30'd12558384;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/tse_mult.sv =====
// Shared unsigned multiplier with registered product.
module tse_mult (
    input  logic                      i_clk,
    input  logic [tse_pkg::MA_W-1:0]  i_a,
    input  logic [tse_pkg::MB_W-1:0]  i_b,
    output logic [tse_pkg::PROD_W-1:0] o_prod
);

    logic [tse_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= tse_pkg::PROD_W'(i_a) * tse_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== design/tse_seq.sv =====
// Sequencer stepping the shared multiplier through square, factor and term products.
module tse_seq #(
    parameter int MAX_TERMS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_out_free,
    input  logic [tse_pkg::CFG_W-1:0]   i_term_count,
    output logic                        o_in_ready,
    output tse_pkg::t_ctrl              o_ctrl
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_X2   = 3'd2;
    localparam logic [2:0] ST_LO   = 3'd3;
    localparam logic [2:0] ST_HI   = 3'd4;
    localparam logic [2:0] ST_ACC  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    localparam logic [tse_pkg::CFG_W-1:0] N_MAX = tse_pkg::CFG_W'(MAX_TERMS);
    localparam logic [tse_pkg::CFG_W-1:0] ONE   = tse_pkg::CFG_W'(1);

    logic [2:0]                r_state, n_state;
    logic [tse_pkg::CFG_W-1:0] r_k, n_k;
    logic [tse_pkg::CFG_W-1:0] r_n, n_n;
    logic [tse_pkg::CFG_W-1:0] clamped;
    logic                      accept;
    logic                      last;

    always_comb begin
        priority if (i_term_count == '0) begin
            clamped = ONE;
        end else if (i_term_count > N_MAX) begin
            clamped = N_MAX;
        end else begin
            clamped = i_term_count;
        end
    end

    assign accept = (r_state == ST_IDLE) && i_in_valid;
    assign last   = (r_k == r_n - ONE);

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_n     = r_n;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_n     = clamped;
                    n_k     = ONE;
                    n_state = (clamped == ONE) ? ST_DONE : ST_SQ;
                end
            end
            ST_SQ:  n_state = ST_X2;
            ST_X2:  n_state = ST_LO;
            ST_LO:  n_state = ST_HI;
            ST_HI:  n_state = ST_ACC;
            ST_ACC: begin
                if (last) begin
                    n_state = ST_DONE;
                end else begin
                    n_k     = r_k + ONE;
                    n_state = ST_LO;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= ONE;
            r_n     <= ONE;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_n     <= n_n;
        end
    end

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_ctrl.accept = accept;
    assign o_ctrl.sq     = (r_state == ST_SQ);
    assign o_ctrl.x2     = (r_state == ST_X2);
    assign o_ctrl.lo     = (r_state == ST_LO);
    assign o_ctrl.hi     = (r_state == ST_HI);
    assign o_ctrl.acc    = (r_state == ST_ACC);
    assign o_ctrl.finish = (r_state == ST_DONE) && i_out_free;
    assign o_ctrl.k      = r_k;

endmodule

// ===== design/taylor_sine_evaluator.sv =====
// Top level of the Taylor sine evaluator: handshakes, datapath registers and result stage.
//
//   channel   direction  handshake                 payload
//   in        request    i_in_valid / o_in_ready   i_angle
//   out       result     o_out_valid / i_out_ready o_sine_value, o_saturated
//   cfg       write      i_cfg_we                  i_cfg_data (term count)
//
// The single multiplier squares the angle, scales the square and then issues three products
// per term after the first; a request with one term goes straight to the result.
// The block accepts one request at a time; the result register frees it for the next.
// A result held by a stalled consumer blocks only the finishing step.
// Reset restores a term count of five and empties the result register.
module taylor_sine_evaluator #(
    parameter int MAX_TERMS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [tse_pkg::ANGLE_W-1:0] i_angle,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [tse_pkg::SINE_W-1:0] o_sine_value,
    output logic                              o_saturated,
    input  logic                              i_cfg_we,
    input  logic [tse_pkg::CFG_W-1:0]         i_cfg_data
);

    tse_pkg::t_ctrl                     ctrl;
    logic [tse_pkg::CFG_W-1:0]          r_term_count;
    logic [tse_pkg::ANGLE_W-1:0]        r_mag;
    logic                               r_neg;
    logic [tse_pkg::X2_W-1:0]           r_x2;
    logic [tse_pkg::F_W-1:0]            r_f;
    logic [tse_pkg::LO_W-1:0]           r_lo;
    logic [tse_pkg::TERM_W-1:0]         r_t;
    logic signed [tse_pkg::ACC_W-1:0]   r_sum;
    logic                               r_tsat;
    logic                               r_out_valid;
    logic [tse_pkg::SINE_W-1:0]         r_sine;
    logic                               r_sat;

    logic [tse_pkg::ANGLE_W-1:0]        mag;
    logic signed [tse_pkg::ACC_W-1:0]   mag_ext;
    logic [tse_pkg::MA_W-1:0]           mul_a;
    logic [tse_pkg::MB_W-1:0]           mul_b;
    logic [tse_pkg::PROD_W-1:0]         prod;
    logic [tse_pkg::FULL_W-1:0]         term_full;
    logic [tse_pkg::TERM_W-1:0]         term_clip;
    logic                               term_ovf;
    logic signed [tse_pkg::ACC_W-1:0]   term_ext;
    logic signed [tse_pkg::ACC_W-1:0]   sum_next;
    logic                               sum_ovf;
    logic [tse_pkg::SINE_W-1:0]         sine_clip;
    logic                               out_free;

    assign out_free = !r_out_valid || i_out_ready;

    tse_seq #(
        .MAX_TERMS (MAX_TERMS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_out_free   (out_free),
        .i_term_count (r_term_count),
        .o_in_ready   (o_in_ready),
        .o_ctrl       (ctrl)
    );

    tse_mult u_mult (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign mag     = i_angle[tse_pkg::ANGLE_W-1] ? (~i_angle + 1'b1) : i_angle;
    assign mag_ext = tse_pkg::ACC_W'(mag);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        priority if (ctrl.sq) begin
            mul_a = tse_pkg::MA_W'(r_mag);
            mul_b = r_mag;
        end else if (ctrl.x2) begin
            mul_a = prod[62:28];
            mul_b = tse_pkg::MB_W'(tse_pkg::recip(tse_pkg::CFG_W'(1)));
        end else if (ctrl.lo) begin
            mul_a = tse_pkg::MA_W'(r_t[31:0]);
            mul_b = prod[63:32];
        end else if (ctrl.hi) begin
            mul_a = tse_pkg::MA_W'(r_t[tse_pkg::TERM_W-1:32]);
            mul_b = r_f;
        end else if (ctrl.acc) begin
            mul_a = r_x2;
            mul_b = tse_pkg::MB_W'(tse_pkg::recip(ctrl.k + 1'b1));
        end
    end

    assign term_full = {1'b0, prod[46:0], 4'b0} + tse_pkg::FULL_W'(r_lo);
    assign term_ovf  = (term_full[tse_pkg::FULL_W-1:tse_pkg::TERM_W] != '0);
    assign term_clip = term_ovf ? tse_pkg::TERM_LIMIT : term_full[tse_pkg::TERM_W-1:0];
    assign term_ext  = tse_pkg::ACC_W'(term_clip);
    assign sum_next  = (r_neg ^ ctrl.k[0]) ? (r_sum - term_ext) : (r_sum + term_ext);

    assign sum_ovf   = !((&r_sum[tse_pkg::ACC_W-1:tse_pkg::SINE_W-1]) ||
                         (~|r_sum[tse_pkg::ACC_W-1:tse_pkg::SINE_W-1]));
    assign sine_clip = sum_ovf ? (r_sum[tse_pkg::ACC_W-1] ? tse_pkg::SUM_LOW : tse_pkg::SUM_HIGH)
                               : r_sum[tse_pkg::SINE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= tse_pkg::TERM_COUNT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_term_count <= i_cfg_data;
            end
            if (ctrl.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.accept) begin
            r_mag  <= mag;
            r_neg  <= i_angle[tse_pkg::ANGLE_W-1];
            r_t    <= tse_pkg::TERM_W'(mag);
            r_sum  <= i_angle[tse_pkg::ANGLE_W-1] ? -mag_ext : mag_ext;
            r_tsat <= 1'b0;
        end
        if (ctrl.x2) begin
            r_x2 <= prod[62:28];
        end
        if (ctrl.lo) begin
            r_f <= prod[63:32];
        end
        if (ctrl.hi) begin
            r_lo <= prod[63:28];
        end
        if (ctrl.acc) begin
            r_t    <= term_clip;
            r_sum  <= sum_next;
            r_tsat <= r_tsat | term_ovf;
        end
        if (ctrl.finish) begin
            r_sine <= sine_clip;
            r_sat  <= r_tsat | sum_ovf;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sine_value = r_sine;
    assign o_saturated  = r_sat;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.accept |=> !o_in_ready)
        else $error("request taken while previous one still in work");

    a_finish_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.finish |=> o_out_valid)
        else $error("finished sum not presented");

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({ctrl.accept, ctrl.sq, ctrl.x2, ctrl.lo, ctrl.hi, ctrl.acc, ctrl.finish}))
        else $error("multiplier claimed by two steps");

    a_term_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.hi |=> ctrl.acc)
        else $error("term product not accumulated");
`endif

endmodule
